### hdl/aarm_pkg.sv
// ----------------------------------------------------------------------------
// aarm_pkg
// Shared types and constants of the axis-angle rotation matrix unit.
// ----------------------------------------------------------------------------
package aarm_pkg;

  // Internal fixed point has 31 fraction bits; one is 2^31.
  localparam int unsigned QI = 31;

  // Field widths of the input and result items.
  localparam int unsigned AXIS_W = 16;
  localparam int unsigned ANG_W  = 16;
  localparam int unsigned OUT_W  = 18;

  // Pi in Q31.
  localparam logic [32:0] PI_Q31 = 33'd6746518852;

  // One in Q31, signed and wide enough for the sine and cosine sums.
  localparam logic signed [33:0] ONE_Q31 = 34'sd2147483648;

  // Work handed from the front to the back: unit axis, sine, cosine.
  typedef struct packed {
    logic signed [32:0] ux;
    logic signed [32:0] uy;
    logic signed [32:0] uz;
    logic signed [32:0] s;
    logic signed [32:0] c;
    logic               degen;
  } aarm_job_t;

  // Divisors of the sine series terms.
  function automatic logic [7:0] sin_div(input logic [2:0] k);
    logic [7:0] d;
    case (k)
      3'd0:    d = 8'd6;
      3'd1:    d = 8'd20;
      3'd2:    d = 8'd42;
      3'd3:    d = 8'd72;
      3'd4:    d = 8'd110;
      3'd5:    d = 8'd156;
      default: d = 8'd156;
    endcase
    return d;
  endfunction

  // Divisors of the cosine series terms.
  function automatic logic [7:0] cos_div(input logic [2:0] k);
    logic [7:0] d;
    case (k)
      3'd0:    d = 8'd2;
      3'd1:    d = 8'd12;
      3'd2:    d = 8'd30;
      3'd3:    d = 8'd56;
      3'd4:    d = 8'd90;
      3'd5:    d = 8'd132;
      default: d = 8'd132;
    endcase
    return d;
  endfunction

  // Reciprocals of the sine divisors, floor(2^32 / d).
  function automatic logic [31:0] sin_rcp(input logic [2:0] k);
    logic [31:0] r;
    case (k)
      3'd0:    r = 32'd715827882;
      3'd1:    r = 32'd214748364;
      3'd2:    r = 32'd102261126;
      3'd3:    r = 32'd59652323;
      3'd4:    r = 32'd39045157;
      3'd5:    r = 32'd27531841;
      default: r = 32'd27531841;
    endcase
    return r;
  endfunction

  // Reciprocals of the cosine divisors, floor(2^32 / d).
  function automatic logic [31:0] cos_rcp(input logic [2:0] k);
    logic [31:0] r;
    case (k)
      3'd0:    r = 32'd2147483648;
      3'd1:    r = 32'd357913941;
      3'd2:    r = 32'd143165576;
      3'd3:    r = 32'd76695844;
      3'd4:    r = 32'd47721858;
      3'd5:    r = 32'd32537631;
      default: r = 32'd32537631;
    endcase
    return r;
  endfunction

endpackage

### hdl/aarm_if.sv
// ----------------------------------------------------------------------------
// aarm_if
// Valid/ready channels of the axis-angle rotation matrix unit.
// ----------------------------------------------------------------------------

// Rotation channel: raw axis and binary angle.
interface aarm_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] axis_x;
  logic signed [15:0] axis_y;
  logic signed [15:0] axis_z;
  logic        [15:0] turn_angle;

  modport source (output valid, axis_x, axis_y, axis_z, turn_angle, input ready);
  modport sink   (input valid, axis_x, axis_y, axis_z, turn_angle, output ready);
endinterface

// Matrix channel: nine entries and the degenerate flag.
interface aarm_out_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] r00;
  logic signed [17:0] r01;
  logic signed [17:0] r02;
  logic signed [17:0] r10;
  logic signed [17:0] r11;
  logic signed [17:0] r12;
  logic signed [17:0] r20;
  logic signed [17:0] r21;
  logic signed [17:0] r22;
  logic               degenerate;

  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  degenerate, input ready);
  modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  degenerate, output ready);
endinterface

### hdl/aarm_front.sv
// ----------------------------------------------------------------------------
// aarm_front
// Takes a rotation, normalises the axis (bit-serial square root and three
// division lanes) and forms sine and cosine by a series whose constant
// divisions use reciprocal multiplication with a one-step correction.
// ----------------------------------------------------------------------------
module aarm_front
  import aarm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  aarm_in_if.sink   in_i,
  output logic      job_valid_o,
  output aarm_job_t job_o,
  input  logic      job_ready_i
);

  typedef enum logic [3:0] {
    F_IDLE, F_LEN, F_SQRT, F_DIV, F_ANG, F_TH2, F_TMUL, F_TDIV, F_TFIX, F_TACC,
    F_QUAD, F_PUSH
  } state_e;

  state_e             state_q;
  logic        [5:0]  cnt_q;
  logic signed [15:0] ax_q, ay_q, az_q;
  logic        [15:0] ang_q;

  // Square root registers.
  logic [62:0] n_q, res_q, bit_q;
  logic [62:0] trial, n_d, res_d;

  // Division lanes, one per axis component.
  logic [31:0] rem_q [3];
  logic [32:0] nlo_q [3];
  logic [32:0] quo_q [3];
  logic [31:0] rem_d [3];
  logic [32:0] quo_d [3];
  logic [15:0] amag [3];
  logic        asgn [3];
  logic [61:0] numer [3];
  logic [32:0] mg [3];

  // Series registers.
  logic        [30:0] th_q, th2_q;
  logic        [2:0]  k_q;
  logic        [31:0] ts_q, tc_q;
  logic        [31:0] sdv_q, cdv_q, squo_q, cquo_q;
  logic signed [33:0] ss_q, cc_q;
  logic               swap_q;
  aarm_job_t          job_q;

  logic signed [31:0] px, py, pz;
  logic        [31:0] len2;
  logic        [13:0] rr, tt;
  logic        [46:0] thp;
  logic        [61:0] t2p;
  logic        [62:0] psp, pcp;
  logic        [7:0]  sd, cd;
  logic        [63:0] srp, crp;
  logic        [39:0] sqd, cqd, srm, crm;
  logic        [31:0] sqf, cqf;
  logic signed [32:0] ssc, ccc, s0, c0;

  // Squared length of the axis.
  always_comb begin
    px   = ax_q * ax_q;
    py   = ay_q * ay_q;
    pz   = az_q * az_q;
    len2 = unsigned'(px) + unsigned'(py) + unsigned'(pz);
  end

  // One digit of the square root.
  always_comb begin
    trial = res_q + bit_q;
    if (n_q >= trial) begin
      n_d   = n_q - trial;
      res_d = (res_q >> 1) + bit_q;
    end else begin
      n_d   = n_q;
      res_d = res_q >> 1;
    end
  end

  // Division set-up and one quotient bit per lane.
  always_comb begin
    amag[0] = ax_q[15] ? 16'(-ax_q) : 16'(ax_q);
    amag[1] = ay_q[15] ? 16'(-ay_q) : 16'(ay_q);
    amag[2] = az_q[15] ? 16'(-az_q) : 16'(az_q);
    asgn[0] = ax_q[15];
    asgn[1] = ay_q[15];
    asgn[2] = az_q[15];
    for (int i = 0; i < 3; i++) begin
      numer[i] = {amag[i], 46'd0} + 62'(res_d[30:1]);
      if ({rem_q[i][30:0], nlo_q[i][32]} >= {1'b0, res_q[30:0]}) begin
        rem_d[i] = {rem_q[i][30:0], nlo_q[i][32]} - {1'b0, res_q[30:0]};
        quo_d[i] = {quo_q[i][31:0], 1'b1};
      end else begin
        rem_d[i] = {rem_q[i][30:0], nlo_q[i][32]};
        quo_d[i] = {quo_q[i][31:0], 1'b0};
      end
      mg[i] = (quo_d[i] > 33'h080000000) ? 33'h080000000 : quo_d[i];
    end
  end

  // Angle reduction and series arithmetic.
  always_comb begin
    rr  = ang_q[13:0];
    tt  = (rr <= 14'd8192) ? rr : 14'(15'd16384 - {1'b0, rr});
    thp = 47'(tt) * 47'(PI_Q31);
    t2p = 62'(th_q) * 62'(th_q);
    psp = 63'(ts_q) * 63'(th2_q);
    pcp = 63'(tc_q) * 63'(th2_q);
    sd  = sin_div(k_q);
    cd  = cos_div(k_q);
    // The reciprocal estimate is the quotient or one below it.
    srp = 64'(sdv_q) * 64'(sin_rcp(k_q));
    crp = 64'(cdv_q) * 64'(cos_rcp(k_q));
    sqd = 40'(squo_q) * 40'(sd);
    cqd = 40'(cquo_q) * 40'(cd);
    srm = 40'(sdv_q) - sqd;
    crm = 40'(cdv_q) - cqd;
    sqf = (srm >= 40'(sd)) ? squo_q + 32'd1 : squo_q;
    cqf = (crm >= 40'(cd)) ? cquo_q + 32'd1 : cquo_q;
    // Clamp the sums to [0, 1] and undo the octant fold.
    if (ss_q < 0)            ssc = '0;
    else if (ss_q > ONE_Q31) ssc = 33'(ONE_Q31);
    else                     ssc = 33'(ss_q);
    if (cc_q < 0)            ccc = '0;
    else if (cc_q > ONE_Q31) ccc = 33'(ONE_Q31);
    else                     ccc = 33'(cc_q);
    s0 = swap_q ? ccc : ssc;
    c0 = swap_q ? ssc : ccc;
  end

  assign in_i.ready  = (state_q == F_IDLE);
  assign job_valid_o = (state_q == F_PUSH);
  assign job_o       = job_q;

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
      k_q     <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (in_i.valid) begin
            ax_q    <= in_i.axis_x;
            ay_q    <= in_i.axis_y;
            az_q    <= in_i.axis_z;
            ang_q   <= in_i.turn_angle;
            state_q <= F_LEN;
          end
        end
        F_LEN: begin
          n_q   <= {1'b0, len2, 30'd0};
          res_q <= '0;
          bit_q <= 63'd1 << 62;
          cnt_q <= '0;
          if (len2 == '0) begin
            job_q   <= '{ux: '0, uy: '0, uz: '0, s: '0, c: '0, degen: 1'b1};
            state_q <= F_PUSH;
          end else begin
            job_q.degen <= 1'b0;
            state_q     <= F_SQRT;
          end
        end
        F_SQRT: begin
          n_q   <= n_d;
          res_q <= res_d;
          bit_q <= bit_q >> 2;
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd31) begin
            for (int i = 0; i < 3; i++) begin
              rem_q[i] <= 32'(numer[i][61:33]);
              nlo_q[i] <= numer[i][32:0];
              quo_q[i] <= '0;
            end
            cnt_q   <= '0;
            state_q <= F_DIV;
          end
        end
        F_DIV: begin
          for (int i = 0; i < 3; i++) begin
            rem_q[i] <= rem_d[i];
            nlo_q[i] <= nlo_q[i] << 1;
            quo_q[i] <= quo_d[i];
          end
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd32) begin
            job_q.ux <= asgn[0] ? -$signed(mg[0]) : $signed(mg[0]);
            job_q.uy <= asgn[1] ? -$signed(mg[1]) : $signed(mg[1]);
            job_q.uz <= asgn[2] ? -$signed(mg[2]) : $signed(mg[2]);
            state_q  <= F_ANG;
          end
        end
        F_ANG: begin
          th_q    <= thp[45:15];
          swap_q  <= (rr > 14'd8192);
          state_q <= F_TH2;
        end
        F_TH2: begin
          th2_q   <= t2p[61:31];
          ts_q    <= 32'(th_q);
          tc_q    <= 32'h80000000;
          ss_q    <= 34'(th_q);
          cc_q    <= ONE_Q31;
          k_q     <= '0;
          state_q <= F_TMUL;
        end
        F_TMUL: begin
          sdv_q   <= psp[62:31];
          cdv_q   <= pcp[62:31];
          state_q <= F_TDIV;
        end
        F_TDIV: begin
          squo_q  <= srp[63:32];
          cquo_q  <= crp[63:32];
          state_q <= F_TFIX;
        end
        F_TFIX: begin
          squo_q  <= sqf;
          cquo_q  <= cqf;
          state_q <= F_TACC;
        end
        F_TACC: begin
          // Terms alternate in sign, the first one subtracted.
          ts_q <= squo_q;
          tc_q <= cquo_q;
          if (k_q[0]) begin
            ss_q <= ss_q + $signed({2'b00, squo_q});
            cc_q <= cc_q + $signed({2'b00, cquo_q});
          end else begin
            ss_q <= ss_q - $signed({2'b00, squo_q});
            cc_q <= cc_q - $signed({2'b00, cquo_q});
          end
          k_q     <= k_q + 3'd1;
          state_q <= (k_q == 3'd5) ? F_QUAD : F_TMUL;
        end
        F_QUAD: begin
          case (ang_q[15:14])
            2'd0:    begin job_q.s <= s0;  job_q.c <= c0;  end
            2'd1:    begin job_q.s <= c0;  job_q.c <= -s0; end
            2'd2:    begin job_q.s <= -s0; job_q.c <= -c0; end
            default: begin job_q.s <= -c0; job_q.c <= s0;  end
          endcase
          state_q <= F_PUSH;
        end
        F_PUSH: begin
          if (job_ready_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

### hdl/aarm_fifo.sv
// ----------------------------------------------------------------------------
// aarm_fifo
// Two-entry queue of prepared jobs between the front and the back.
// ----------------------------------------------------------------------------
module aarm_fifo
  import aarm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  input  aarm_job_t push_data_i,
  output logic      pop_valid_o,
  input  logic      pop_ready_i,
  output aarm_job_t pop_data_o
);

  aarm_job_t  mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      if (push && !pop)      cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

### hdl/aarm_back.sv
// ----------------------------------------------------------------------------
// aarm_back
// Builds the nine matrix entries with one shared multiplier, rounds them to
// the output format and holds the result in an output register.
// ----------------------------------------------------------------------------
module aarm_back
  import aarm_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_valid_i,
  output logic      job_ready_o,
  input  aarm_job_t job_i,
  aarm_out_if.source res_o
);

  localparam int unsigned SH = QI - FRAC_BITS;
  localparam logic [35:0] HALF = 36'd1 << (SH - 1);
  localparam logic [35:0] LIM  = 36'd1 << FRAC_BITS;

  typedef enum logic [1:0] {B_IDLE, B_MUL, B_SUM, B_FIN} state_e;

  state_e             state_q;
  logic        [3:0]  cnt_q, dst_q;
  logic               degen_q;
  logic        [31:0] um_q [3];
  logic               us_q [3];
  logic        [31:0] sm_q;
  logic               ssg_q;
  logic signed [32:0] c_q;
  logic        [32:0] omc_q;
  logic        [31:0] uum_q [6];
  logic               uus_q [6];
  logic signed [34:0] w_q [6];
  logic signed [33:0] v_q [3];
  logic        [65:0] prod_q;
  logic               psg_q;
  logic signed [35:0] m_q [9];
  logic        [17:0] r_q [9];
  logic               rdeg_q, ovalid_q;

  logic        [32:0] opa, opb;
  logic               osg;
  logic        [2:0]  widx;
  logic        [33:0] pmag;
  logic signed [33:0] omc_w;
  logic               load_out;

  // Rounds half away from zero, clamps to one and keeps the field width.
  function automatic logic [17:0] to_out(input logic signed [35:0] v);
    logic [35:0] mag, r;
    mag = v[35] ? 36'(-v) : 36'(v);
    r   = (mag + HALF) >> SH;
    if (r > LIM) r = LIM;
    if (v[35])   r = -r;
    return r[17:0];
  endfunction

  // Operand selection for the multiplier schedule.
  always_comb begin
    widx = 3'(cnt_q - 4'd6);
    opa  = '0;
    opb  = '0;
    osg  = 1'b0;
    case (cnt_q)
      4'd0:  begin opa = 33'(um_q[0]); opb = 33'(um_q[0]); end
      4'd1:  begin opa = 33'(um_q[1]); opb = 33'(um_q[1]); end
      4'd2:  begin opa = 33'(um_q[2]); opb = 33'(um_q[2]); end
      4'd3:  begin opa = 33'(um_q[0]); opb = 33'(um_q[1]); osg = us_q[0] ^ us_q[1]; end
      4'd4:  begin opa = 33'(um_q[0]); opb = 33'(um_q[2]); osg = us_q[0] ^ us_q[2]; end
      4'd5:  begin opa = 33'(um_q[1]); opb = 33'(um_q[2]); osg = us_q[1] ^ us_q[2]; end
      4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11: begin
        opa = 33'(uum_q[widx]);
        opb = omc_q;
        osg = uus_q[widx];
      end
      4'd12: begin opa = 33'(um_q[2]); opb = 33'(sm_q); osg = us_q[2] ^ ssg_q; end
      4'd13: begin opa = 33'(um_q[1]); opb = 33'(sm_q); osg = us_q[1] ^ ssg_q; end
      4'd14: begin opa = 33'(um_q[0]); opb = 33'(sm_q); osg = us_q[0] ^ ssg_q; end
      default: begin opa = '0; opb = '0; osg = 1'b0; end
    endcase
    pmag     = prod_q[64:31];
    omc_w    = ONE_Q31 - 34'(job_i.c);
    load_out = (state_q == B_FIN) && (!ovalid_q || res_o.ready);
  end

  assign job_ready_o = (state_q == B_IDLE);

  // Multiplier pipeline and entry sums.
  always_ff @(posedge clk_i) begin
    if (state_q == B_IDLE && job_valid_i) begin
      um_q[0] <= job_i.ux[32] ? 32'(-job_i.ux) : 32'(job_i.ux);
      um_q[1] <= job_i.uy[32] ? 32'(-job_i.uy) : 32'(job_i.uy);
      um_q[2] <= job_i.uz[32] ? 32'(-job_i.uz) : 32'(job_i.uz);
      us_q[0] <= job_i.ux[32];
      us_q[1] <= job_i.uy[32];
      us_q[2] <= job_i.uz[32];
      sm_q    <= job_i.s[32] ? 32'(-job_i.s) : 32'(job_i.s);
      ssg_q   <= job_i.s[32];
      c_q     <= job_i.c;
      omc_q   <= omc_w[32:0];
      degen_q <= job_i.degen;
    end
    if (state_q == B_MUL) begin
      prod_q <= 66'(opa) * 66'(opb);
      psg_q  <= osg;
      dst_q  <= cnt_q;
      if (cnt_q != 4'd0) begin
        case (dst_q)
          4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5: begin
            uum_q[3'(dst_q)] <= pmag[31:0];
            uus_q[3'(dst_q)] <= psg_q;
          end
          4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11: begin
            w_q[3'(dst_q - 4'd6)] <= psg_q ? -$signed({2'b00, pmag[32:0]})
                                           :  $signed({2'b00, pmag[32:0]});
          end
          default: begin
            v_q[2'(dst_q - 4'd12)] <= psg_q ? -$signed({2'b00, pmag[31:0]})
                                            :  $signed({2'b00, pmag[31:0]});
          end
        endcase
      end
    end
    if (state_q == B_SUM) begin
      m_q[0] <= 36'(c_q) + 36'(w_q[0]);
      m_q[4] <= 36'(c_q) + 36'(w_q[1]);
      m_q[8] <= 36'(c_q) + 36'(w_q[2]);
      m_q[1] <= 36'(w_q[3]) - 36'(v_q[0]);
      m_q[3] <= 36'(w_q[3]) + 36'(v_q[0]);
      m_q[2] <= 36'(w_q[4]) + 36'(v_q[1]);
      m_q[6] <= 36'(w_q[4]) - 36'(v_q[1]);
      m_q[5] <= 36'(w_q[5]) - 36'(v_q[2]);
      m_q[7] <= 36'(w_q[5]) + 36'(v_q[2]);
    end
    if (load_out) begin
      for (int i = 0; i < 9; i++) begin
        if (degen_q) r_q[i] <= ((i % 4) == 0) ? LIM[17:0] : '0;
        else         r_q[i] <= to_out(m_q[i]);
      end
      rdeg_q <= degen_q;
    end
  end

  // Control: schedule counter, state and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (res_o.ready) ovalid_q <= 1'b0;
      case (state_q)
        B_IDLE: begin
          cnt_q <= '0;
          if (job_valid_i) begin
            state_q <= job_i.degen ? B_FIN : B_MUL;
          end
        end
        B_MUL: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd15) state_q <= B_SUM;
        end
        B_SUM: state_q <= B_FIN;
        B_FIN: begin
          if (load_out) begin
            ovalid_q <= 1'b1;
            state_q  <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  assign res_o.valid      = ovalid_q;
  assign res_o.r00        = r_q[0];
  assign res_o.r01        = r_q[1];
  assign res_o.r02        = r_q[2];
  assign res_o.r10        = r_q[3];
  assign res_o.r11        = r_q[4];
  assign res_o.r12        = r_q[5];
  assign res_o.r20        = r_q[6];
  assign res_o.r21        = r_q[7];
  assign res_o.r22        = r_q[8];
  assign res_o.degenerate = rdeg_q;

endmodule

### hdl/axis_angle_rotation_matrix_unit.sv
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix_unit
// Turns an axis and a binary angle into a 3x3 rotation matrix.
// ----------------------------------------------------------------------------
// Use: a rotation (raw axis x, y, z and a 16-bit angle, full turn 65536) is
// a transfer on in_i; the matching matrix, nine signed Q1.FRAC_BITS entries
// and a degenerate flag, is a transfer on res_o. One matrix per rotation, in
// order.
// The front normalises the axis by the bit-serial square root and the three
// division lanes, then forms 6 series terms, each by product, reciprocal
// estimate, correction and sum, plus set-up, quadrant and hand-over. A
// zero-length axis skips this work and yields the identity with the
// degenerate flag. The back forms 15 products through a single shared
// multiplier, then one sum stage and rounding into the output register.
// The front takes a new rotation only once it has handed its job on; the
// back then works on that job while the front takes the next rotation.
// A two-entry queue sits between front and back, and the output register
// lets the back start the next job while a matrix is still waiting.
// When the receiver stalls, the result holds on res_o, the queue fills and
// in_i.ready stays low once the front has nowhere to put its job.
// Reset idles both sequencers and empties the queue and the output register.
module axis_angle_rotation_matrix_unit
  import aarm_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  aarm_in_if.sink     in_i,
  aarm_out_if.source  res_o
);

  logic      f_valid, f_ready, b_valid, b_ready;
  aarm_job_t f_job, b_job;

  // Normalisation and sine/cosine.
  aarm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .job_valid_o (f_valid),
    .job_o       (f_job),
    .job_ready_i (f_ready)
  );

  // Job queue.
  aarm_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_job),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_job)
  );

  // Matrix products and output.
  aarm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (b_valid),
    .job_ready_o (b_ready),
    .job_i       (b_job),
    .res_o       (res_o)
  );

endmodule

### hdl/aarm_checker.sv
// ----------------------------------------------------------------------------
// aarm_checker
// Port-level checks of the rotation matrix unit, bound to the top level.
// ----------------------------------------------------------------------------
module aarm_checker #(
  parameter int unsigned FRAC_BITS = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [17:0] r00_i,
  input logic [17:0] r01_i,
  input logic [17:0] r02_i,
  input logic [17:0] r10_i,
  input logic [17:0] r11_i,
  input logic [17:0] r12_i,
  input logic [17:0] r20_i,
  input logic [17:0] r21_i,
  input logic [17:0] r22_i,
  input logic        degenerate_i
);

  localparam logic [35:0] ONE_W = 36'd1 << FRAC_BITS;
  localparam logic [17:0] ONE   = ONE_W[17:0];

  logic [2:0] pend_q;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  // Rotations taken but not yet answered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_xfer && !out_xfer) begin
      pend_q <= pend_q + 3'd1;
    end else if (out_xfer && !in_xfer) begin
      pend_q <= pend_q - 3'd1;
    end
  end

  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its value; r00, r12, r21 and the flag are checked.
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(r00_i) && $stable(r12_i) &&
    $stable(r21_i) && $stable(degenerate_i))
    else $error("result changed while stalled");

  // No matrix without a rotation waiting for it.
  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 3'd0)
    else $error("matrix without a pending rotation");

  // A degenerate axis yields the identity.
  a_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && degenerate_i |-> r00_i == ONE && r11_i == ONE && r22_i == ONE &&
    r01_i == '0 && r02_i == '0 && r10_i == '0 && r12_i == '0 && r20_i == '0 &&
    r21_i == '0)
    else $error("degenerate result is not the identity");

endmodule

bind axis_angle_rotation_matrix_unit aarm_checker #(.FRAC_BITS(FRAC_BITS)) u_aarm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (res_o.valid),
  .out_ready_i  (res_o.ready),
  .r00_i        (res_o.r00),
  .r01_i        (res_o.r01),
  .r02_i        (res_o.r02),
  .r10_i        (res_o.r10),
  .r11_i        (res_o.r11),
  .r12_i        (res_o.r12),
  .r20_i        (res_o.r20),
  .r21_i        (res_o.r21),
  .r22_i        (res_o.r22),
  .degenerate_i (res_o.degenerate)
);
